[rtl/srrip_way_replacement_macros.svh]
// Assertion macros for the SRRIP way replacement block
`ifndef SRRIP_WAY_REPLACEMENT_MACROS_SVH
`define SRRIP_WAY_REPLACEMENT_MACROS_SVH

// same-cycle implication on clk, off during reset
`define SRRIP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define SRRIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/srrip_pkg.sv]
// Shared types and constants for the SRRIP way replacement block
package srrip_pkg;

	localparam int SET_IDX_W = 11;
	localparam int WAY_IDX_W = 4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_MODIFY
	} srrip_state_t;

	typedef enum logic {
		CMD_FIND   = 1'b0,
		CMD_UPDATE = 1'b1
	} srrip_cmd_t;

	typedef struct packed {
		srrip_cmd_t             cmd;
		logic [WAY_IDX_W-1:0]   way;
		logic                   hit;
	} srrip_req_t;

endpackage

[rtl/srrip_idx.sv]
// Two-stage reduction of the request set index modulo the set count
module srrip_idx #(
	parameter int NUM_SETS = 2048,
	localparam int SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  logic                           clk,
	input  logic                           load,
	input  logic [srrip_pkg::SET_IDX_W-1:0] set_index,
	output logic [SetW-1:0]                set_idx
);
	import srrip_pkg::*;

	localparam int LoSplit = 6;

	logic [SET_IDX_W-1:0] part;
	logic [SET_IDX_W-1:0] rem_s1;
	logic [SET_IDX_W-1:0] full;

	always_comb begin
		part = set_index;
		for (int k = SET_IDX_W - 1; k >= LoSplit; k--) begin
			if (32'(part) >= (32'(NUM_SETS) << k)) begin
				part = part - SET_IDX_W'(32'(NUM_SETS) << k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_s1 <= part;
		end
	end

	always_comb begin
		full = rem_s1;
		for (int k = LoSplit - 1; k >= 0; k--) begin
			if (32'(full) >= (32'(NUM_SETS) << k)) begin
				full = full - SET_IDX_W'(32'(NUM_SETS) << k);
			end
		end
	end

	assign set_idx = SetW'(full);

endmodule

[rtl/srrip_age.sv]
// Set word modify: aging with victim pick, or hit/fill update of one way
module srrip_age #(
	parameter int NUM_WAYS = 16,
	parameter int MAX_PREDICTION = 3,
	localparam int PredW = $clog2(MAX_PREDICTION + 1),
	localparam int WayW = $clog2(NUM_WAYS),
	localparam int WordW = NUM_WAYS * PredW
) (
	input  srrip_pkg::srrip_req_t req,
	input  logic [WordW-1:0]      rd_word,
	output logic [WordW-1:0]      wr_word,
	output logic [WayW-1:0]       victim
);
	import srrip_pkg::*;

	logic [MAX_PREDICTION:0] present;
	logic [PredW-1:0]        top;
	logic [PredW-1:0]        lift;
	logic [NUM_WAYS-1:0]     match;
	logic [NUM_WAYS-1:0]     first;

	always_comb begin
		present = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			for (int v = 0; v <= MAX_PREDICTION; v++) begin
				if (rd_word[w*PredW +: PredW] == PredW'(v)) begin
					present[v] = 1'b1;
				end
			end
		end
		top = '0;
		for (int v = 0; v <= MAX_PREDICTION; v++) begin
			if (present[v]) begin
				top = PredW'(v);
			end
		end
	end

	assign lift = PredW'(MAX_PREDICTION) - top;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			match[w] = (rd_word[w*PredW +: PredW] == top);
		end
	end

	assign first = match & (~match + NUM_WAYS'(1));

	always_comb begin
		victim = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (first[w]) begin
				victim = victim | WayW'(w);
			end
		end
	end

	always_comb begin
		wr_word = rd_word;
		if (req.cmd == CMD_FIND) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				wr_word[w*PredW +: PredW] = rd_word[w*PredW +: PredW] + lift;
			end
		end else if (32'(req.way) < 32'(NUM_WAYS)) begin
			wr_word[WayW'(req.way)*PredW +: PredW] =
				req.hit ? '0 : PredW'(MAX_PREDICTION - 1);
		end
	end

endmodule

[rtl/srrip_way_replacement.sv]
// Top level of the SRRIP cache way replacement block
// A request is taken when start is high and busy is low. It runs in three steps: the accept
// cycle does the high-order subtractions of the set index reduction, the next finishes it and
// reads the prediction table, and the last ages or updates the set word and writes it back.
// Busy is high in the reduce and modify steps, so a new request cannot enter until the last
// one is written back; the table read followed by the write-back of the same set forces this.
// A find-victim request shows victim_way with done for exactly one cycle, the first cycle with
// busy low again; the receiver cannot stall it and must take it then. An update gives no
// result. After reset the table is initialized one set per cycle, all NUM_SETS sets, with busy
// high.
module srrip_way_replacement #(
	parameter int NUM_SETS = 2048,
	parameter int NUM_WAYS = 16,
	parameter int MAX_PREDICTION = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            cmd,
	input  logic [srrip_pkg::SET_IDX_W-1:0] set_index,
	input  logic [srrip_pkg::WAY_IDX_W-1:0] way_index,
	input  logic                            was_hit,
	output logic                            busy,
	output logic                            done,
	output logic [srrip_pkg::WAY_IDX_W-1:0] victim_way
);
	import srrip_pkg::*;

	localparam int SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int PredW = $clog2(MAX_PREDICTION + 1);
	localparam int WayW = $clog2(NUM_WAYS);
	localparam int WordW = NUM_WAYS * PredW;

	srrip_state_t     state_q;
	srrip_state_t     state_d;
	srrip_req_t       req_q;
	logic [SetW-1:0]  clr_q;
	logic             done_q;
	logic [WayW-1:0]  vict_q;
	logic [SetW-1:0]  set_s2;
	logic [WordW-1:0] rd_q;
	logic [WordW-1:0] mem [NUM_SETS];

	logic             accept;
	logic             clr_last;
	logic [SetW-1:0]  set_idx;
	logic [WordW-1:0] mod_word;
	logic [WayW-1:0]  victim;
	logic             mem_we;
	logic             mem_re;
	logic [SetW-1:0]  mem_waddr;
	logic [WordW-1:0] mem_wdata;

	assign accept   = start & ~busy;
	assign clr_last = (clr_q == SetW'(NUM_SETS - 1));

	srrip_idx #(
		.NUM_SETS(NUM_SETS)
	) u_idx (
		.clk      (clk),
		.load     (accept),
		.set_index(set_index),
		.set_idx  (set_idx)
	);

	srrip_age #(
		.NUM_WAYS      (NUM_WAYS),
		.MAX_PREDICTION(MAX_PREDICTION)
	) u_age (
		.req    (req_q),
		.rd_word(rd_q),
		.wr_word(mod_word),
		.victim (victim)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
			ST_IDLE:   if (accept) state_d = ST_REDUCE;
			ST_REDUCE: state_d = ST_MODIFY;
			ST_MODIFY: state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = set_s2;
		mem_wdata = mod_word;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {NUM_WAYS{PredW'(MAX_PREDICTION)}};
			end
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_REDUCE: begin
				mem_re = 1'b1;
			end
			ST_MODIFY: begin
				mem_we = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SetW'(1);
			end
			done_q <= (state_q == ST_MODIFY) && (req_q.cmd == CMD_FIND);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= '{cmd: srrip_cmd_t'(cmd), way: way_index, hit: was_hit};
		end
		if (state_q == ST_REDUCE) begin
			set_s2 <= set_idx;
		end
		if (state_q == ST_MODIFY) begin
			vict_q <= victim;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[set_idx];
		end
	end

	assign done       = done_q;
	assign victim_way = WAY_IDX_W'(vict_q);

endmodule

[rtl/srrip_chk.sv]
// Port-level checks for the SRRIP way replacement block, bound to the top
`include "srrip_way_replacement_macros.svh"

module srrip_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cmd,
	input logic done
);

	`SRRIP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
	`SRRIP_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
	`SRRIP_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
	`SRRIP_ASSERT_NOW(a_find_result, start && !busy && !cmd, ##3 done, "find beat gave no result")
	`SRRIP_ASSERT_NOW(a_update_quiet, start && !busy && cmd, ##3 !done, "update beat gave a result")

endmodule

bind srrip_way_replacement srrip_chk u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done)
);

[tb/sv/testbench.sv]
// Testbench for srrip_way_replacement: directed and random requests against a predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import srrip_pkg::*;

	localparam int NUM_SETS = 2048;
	localparam int NUM_WAYS = 16;
	localparam logic [1:0] RRPV_MAX = 2'd3;
	localparam logic [1:0] RRPV_FILL = RRPV_MAX - 2'd1;
	localparam int CYCLE_LIMIT = 120000;
	localparam int DRAIN_CYCLES = 8;
	localparam int EXP_DEPTH = 2048;
	localparam int EXP_IDX_W = $clog2(EXP_DEPTH);

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 cmd;
	logic [SET_IDX_W-1:0] set_index;
	logic [WAY_IDX_W-1:0] way_index;
	logic                 was_hit;
	logic                 busy;
	logic                 done;
	logic [WAY_IDX_W-1:0] victim_way;

	logic [1:0]           rrpv [NUM_SETS][NUM_WAYS];
	logic [WAY_IDX_W-1:0] exp_victims [EXP_DEPTH];
	int                   exp_head;
	int                   exp_tail;
	logic [SET_IDX_W-1:0] hot_sets [8];
	bit                   gaps_on;
	int                   beats_sent;
	int                   fail_count;
	int                   cycle_count;

	srrip_way_replacement uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.set_index(set_index),
		.way_index(way_index),
		.was_hit(was_hit),
		.busy(busy),
		.done(done),
		.victim_way(victim_way)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		logic [WAY_IDX_W-1:0] want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (exp_head == exp_tail) begin
				$error("victim_way: no result expected, actual %0d", victim_way);
				fail_count++;
			end else begin
				want = exp_victims[EXP_IDX_W'(exp_head)];
				exp_head++;
				if (victim_way !== want) begin
					$error("victim_way: expected %0d, actual %0d", want, victim_way);
					fail_count++;
				end
			end
		end
	end

	function automatic logic [WAY_IDX_W-1:0] predict_victim(logic [SET_IDX_W-1:0] s);
		logic [1:0]           top;
		logic [1:0]           lift;
		logic [WAY_IDX_W-1:0] pick;
		bit                   found;
		top = 2'd0;
		pick = '0;
		found = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++)
			if (rrpv[s][WAY_IDX_W'(w)] > top)
				top = rrpv[s][WAY_IDX_W'(w)];
		lift = RRPV_MAX - top;
		for (int w = 0; w < NUM_WAYS; w++)
			rrpv[s][WAY_IDX_W'(w)] = rrpv[s][WAY_IDX_W'(w)] + lift;
		for (int w = 0; w < NUM_WAYS; w++)
			if (!found && rrpv[s][WAY_IDX_W'(w)] == RRPV_MAX) begin
				pick = WAY_IDX_W'(w);
				found = 1'b1;
			end
		return pick;
	endfunction

	task automatic issue(input srrip_cmd_t c, input logic [SET_IDX_W-1:0] s,
			input logic [WAY_IDX_W-1:0] w, input logic h,
			output logic [WAY_IDX_W-1:0] victim);
		int g;
		@(negedge clk);
		if (gaps_on && $urandom_range(99) < 20) begin
			g = $urandom_range(6, 1);
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		set_index <= s;
		way_index <= w;
		was_hit <= h;
		do @(posedge clk); while (busy !== 1'b0);
		beats_sent++;
		victim = '0;
		if (c == CMD_FIND) begin
			victim = predict_victim(s);
			exp_victims[EXP_IDX_W'(exp_tail)] = victim;
			exp_tail++;
		end else if (int'(w) < NUM_WAYS) begin
			rrpv[s][w] = h ? 2'd0 : RRPV_FILL;
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (exp_head != exp_tail) @(posedge clk);
	endtask

	task automatic run_sequence();
		logic [SET_IDX_W-1:0] s;
		logic [WAY_IDX_W-1:0] v;
		logic [WAY_IDX_W-1:0] unused;
		int                   k;
		if ($urandom_range(99) < 15) begin
			issue(srrip_cmd_t'($urandom_range(1)), SET_IDX_W'($urandom),
				WAY_IDX_W'($urandom), 1'($urandom), unused);
			return;
		end
		s = ($urandom_range(99) < 75) ? hot_sets[3'($urandom_range(7))] : SET_IDX_W'($urandom);
		issue(CMD_FIND, s, WAY_IDX_W'($urandom), 1'($urandom), v);
		if ($urandom_range(99) < 85)
			issue(CMD_UPDATE, s, v, 1'b0, unused);
		k = $urandom_range(4);
		repeat (k)
			issue(CMD_UPDATE, s, ($urandom_range(99) < 40) ? v : WAY_IDX_W'($urandom),
				$urandom_range(99) < 80, unused);
	endtask

	task automatic test_reset_state();
		logic [WAY_IDX_W-1:0] v;
		gaps_on = 1'b0;
		issue(CMD_FIND, '0, '1, 1'b1, v);
		issue(CMD_FIND, '1, '0, 1'b0, v);
		issue(CMD_FIND, '0, 4'd7, 1'b0, v);
		issue(CMD_UPDATE, '1, '0, 1'b0, v);
		issue(CMD_FIND, '1, '1, 1'b1, v);
	endtask

	task automatic test_aging();
		logic [WAY_IDX_W-1:0] v;
		gaps_on = 1'b1;
		for (int w = 0; w < NUM_WAYS; w++)
			issue(CMD_UPDATE, 11'd1024, WAY_IDX_W'(w), w < 9, v);
		issue(CMD_FIND, 11'd1024, '0, 1'b0, v);
		issue(CMD_FIND, 11'd1024, '1, 1'b1, v);
	endtask

	task automatic test_random_traffic(input int beats, input bit with_gaps);
		int stop_at;
		gaps_on = with_gaps;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at)
			run_sequence();
	endtask

	task automatic test_pause_and_resume(input int beats);
		drain_results();
		test_random_traffic(beats, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_FIND;
		set_index = '0;
		way_index = '0;
		was_hit = 1'b0;
		gaps_on = 1'b0;
		beats_sent = 0;
		fail_count = 0;
		cycle_count = 0;
		exp_head = 0;
		exp_tail = 0;
		foreach (rrpv[s, w])
			rrpv[s][w] = RRPV_MAX;
		hot_sets[0] = '0;
		hot_sets[1] = '1;
		for (int i = 2; i < 8; i++)
			hot_sets[3'(i)] = SET_IDX_W'($urandom);
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_aging();
		test_random_traffic(600, 1'b1);
		test_random_traffic(300, 1'b0);
		test_pause_and_resume(500);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && exp_head == exp_tail)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
